FILE: hw/rtl/sdspi_pkg.sv
// Shared types, codes and the CRC7 function of the SD SPI command engine.
package sdspi_pkg;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  // Input selector codes carried in tuser.
  localparam logic OP_START = 1'b0;
  localparam logic OP_RX    = 1'b1;

  // Result kinds carried in tuser.
  localparam logic KIND_SEND   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ERROR   = 2'd1;
  localparam logic [1:0] ST_NO_RESP = 2'd2;

  // Frame position codes: 0..5 are frame bytes, 6 is the first poll, 7 is polling.
  localparam logic [2:0] PH_CMD       = 3'd0;
  localparam logic [2:0] PH_ARG3      = 3'd1;
  localparam logic [2:0] PH_ARG2      = 3'd2;
  localparam logic [2:0] PH_ARG1      = 3'd3;
  localparam logic [2:0] PH_ARG0      = 3'd4;
  localparam logic [2:0] PH_CRC       = 3'd5;
  localparam logic [2:0] PH_POLL_INIT = 3'd6;
  localparam logic [2:0] PH_POLL      = 3'd7;

  localparam logic [7:0] DUMMY_BYTE      = 8'hFF;
  localparam logic [7:0] POLL_LIMIT_RST  = 8'd9;
  localparam logic [6:0] CRC7_POLY       = 7'h09;
  localparam logic [1:0] CMD_START_BITS  = 2'b01;

  typedef struct packed {
    logic        op;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic [7:0] r1_value;
    logic [1:0] status_code;
  } out_item_t;

  // Bit-serial CRC7 over the 40 command bits, unrolled into an XOR network.
  function automatic logic [6:0] crc7(input logic [5:0] cmd, input logic [31:0] arg);
    logic [39:0] bits;
    logic [6:0]  crc;
    logic        fb;
    bits = {CMD_START_BITS, cmd, arg};
    crc  = '0;
    for (int i = 39; i >= 0; i--) begin
      fb  = crc[6] ^ bits[i];
      crc = {crc[5:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC7_POLY;
      end
    end
    return crc;
  endfunction

endpackage

FILE: hw/rtl/sdspi_in_reg.sv
// Input register stage of the SD SPI command engine.
module sdspi_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sdspi_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              q_valid,
  output sdspi_pkg::in_item_t q_item
);
  import sdspi_pkg::*;

  logic take;

  // The register can load whenever it is empty or its item moves on this cycle.
  assign in_ready = !q_valid || advance;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (take) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_item <= in_item;
    end
  end

endmodule

FILE: hw/rtl/sdspi_ctrl.sv
// Command sequencer: CRC, frame byte selection, R1 polling and the poll limit register.
module sdspi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  input  logic                advance,
  input  sdspi_pkg::in_item_t q_item,
  output logic                res_valid,
  output sdspi_pkg::out_item_t res_item
);
  import sdspi_pkg::*;

  logic        busy, busy_next;
  logic [2:0]  phase, phase_next;
  logic [7:0]  poll_count, poll_count_next;
  logic [7:0]  poll_limit;
  logic [5:0]  held_command;
  logic [31:0] held_argument;
  logic [6:0]  held_crc;
  logic        load;
  logic [7:0]  frame_byte;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= POLL_LIMIT_RST;
    end else if (cfg_valid) begin
      poll_limit <= cfg_data;
    end
  end

  always_comb begin
    unique case (phase)
      PH_CMD:  frame_byte = {2'b01, held_command};
      PH_ARG3: frame_byte = held_argument[31:24];
      PH_ARG2: frame_byte = held_argument[23:16];
      PH_ARG1: frame_byte = held_argument[15:8];
      PH_ARG0: frame_byte = held_argument[7:0];
      default: frame_byte = {held_crc, 1'b1};
    endcase
  end

  always_comb begin
    busy_next       = busy;
    phase_next      = phase;
    poll_count_next = poll_count;
    load            = 1'b0;
    res_valid       = 1'b0;
    res_item        = '{kind: KIND_SEND, tx_byte: DUMMY_BYTE, r1_value: 8'd0,
                        status_code: ST_OK};
    priority if (q_item.op == OP_START) begin
      load            = 1'b1;
      busy_next       = 1'b1;
      phase_next      = PH_CMD;
      poll_count_next = 8'd0;
      res_valid       = 1'b1;
    end else if (!busy) begin
      res_valid = 1'b0;
    end else if (phase <= PH_CRC) begin
      phase_next       = phase + 3'd1;
      res_valid        = 1'b1;
      res_item.tx_byte = frame_byte;
    end else if (phase == PH_POLL_INIT) begin
      phase_next      = PH_POLL;
      poll_count_next = 8'd1;
      res_valid       = 1'b1;
    end else if (!q_item.rx_byte[7]) begin
      // The card answered: bits 2 and 3 are illegal command and CRC error.
      busy_next  = 1'b0;
      phase_next = PH_CMD;
      res_valid  = 1'b1;
      res_item   = '{kind: KIND_STATUS, tx_byte: 8'd0, r1_value: q_item.rx_byte,
                     status_code: (q_item.rx_byte[3:2] != 2'b00) ? ST_ERROR : ST_OK};
    end else if (poll_count >= poll_limit) begin
      busy_next  = 1'b0;
      phase_next = PH_CMD;
      res_valid  = 1'b1;
      res_item   = '{kind: KIND_STATUS, tx_byte: 8'd0, r1_value: 8'd0,
                     status_code: ST_NO_RESP};
    end else begin
      poll_count_next = poll_count + 8'd1;
      res_valid       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      phase      <= PH_CMD;
      poll_count <= 8'd0;
    end else if (advance) begin
      busy       <= busy_next;
      phase      <= phase_next;
      poll_count <= poll_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      held_command  <= q_item.cmd_index;
      held_argument <= q_item.argument;
      held_crc      <= crc7(q_item.cmd_index, q_item.argument);
    end
  end

endmodule

FILE: hw/rtl/sdspi_out_reg.sv
// Result register stage of the SD SPI command engine.
module sdspi_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 res_valid,
  input  sdspi_pkg::out_item_t res_item,
  output logic                 out_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sdspi_pkg::out_item_t out_item
);
  import sdspi_pkg::*;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_item <= res_item;
    end
  end

endmodule

FILE: hw/rtl/sd_spi_command_engine_core.sv
// Top level of the SD card SPI-mode command engine.
//
// The input stream carries either a command start (tuser 0, with command index
// and argument) or a byte received from the card (tuser 1). For each accepted
// item the engine gives at most one result on the output stream: a byte to
// shift out (tuser 0) or the final status (tuser 1). A start sends a dummy
// 0xFF; each received byte then releases the next of the six frame bytes, the
// last one holding the CRC7, and afterwards the 0xFF polls until an R1 byte
// arrives or the poll limit runs out. A start while busy restarts the exchange.
// The cfg channel writes the poll limit; it is always ready. The user must write
// it only while the engine is idle; the block itself does not enforce this.
// An accepted item is registered in the input register and its result in the
// result register; one item is taken per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and one more item waits
// in the input register before s_axis_tready drops. Reset empties both
// registers, makes the engine idle and sets the poll limit to 9.
module sd_spi_command_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: cmd_index[5:0], argument[37:6], rx_byte[45:38], zero fill.
  input  logic [sdspi_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // tuser: op.
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: tx_byte[7:0], r1_value[15:8], status_code[17:16], zero fill.
  output logic [sdspi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: kind.
  output logic        m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import sdspi_pkg::*;

  in_item_t  in_item;
  in_item_t  q_item;
  out_item_t res_item;
  out_item_t out_item;
  logic      q_valid;
  logic      advance;
  logic      out_free;
  logic      res_valid;

  assign in_item = '{op: s_axis_tuser, cmd_index: s_axis_tdata[5:0],
                     argument: s_axis_tdata[37:6], rx_byte: s_axis_tdata[45:38]};

  assign advance = q_valid && out_free;

  sdspi_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  sdspi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .q_item    (q_item),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  sdspi_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .res_valid (res_valid),
    .res_item  (res_item),
    .out_free  (out_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (out_item)
  );

  assign m_axis_tuser = out_item.kind;
  assign m_axis_tdata = {6'd0, out_item.status_code, out_item.r1_value, out_item.tx_byte};

endmodule

FILE: hw/rtl/sdspi_checker.sv
// Port-level assertions for the SD SPI command engine, bound to the top level.
module sdspi_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [sdspi_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import sdspi_pkg::*;

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A send result carries no R1 and no status code.
  a_send_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_SEND |->
      m_axis_tdata[17:8] == 10'd0)
    else $error("send result with status fields set");

  // A status result sends nothing, and an error-free R1 has its flag bits clear.
  a_status_sane: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_STATUS |->
      m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[17:16] != 2'd3 &&
      (m_axis_tdata[17:16] != ST_OK || (m_axis_tdata[15:8] & 8'h8C) == 8'd0))
    else $error("malformed status result");

  // Every new result comes from an input transfer, through the input register and the result register.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without an input transfer");

endmodule

bind sd_spi_command_engine_core sdspi_checker u_sdspi_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
